// ===== src/utf8_to_utf16_transcoder_defines.svh =====
// Assertion macros shared by the transcoder modules.
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

// Plain property checked on every clock edge outside reset.
`define U2U_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("u2u assertion failed");

// Implication checked on every clock edge outside reset.
`define U2U_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u2u implication failed");

`endif

// ===== src/u2u_pkg.sv =====
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
package u2u_pkg;

    localparam logic [20:0] CP_BMP_MAX   = 21'h00FFFF;
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
    localparam logic [15:0] HI_SURR      = 16'hD800;
    localparam logic [15:0] LO_SURR      = 16'hDC00;

    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    // Units produced by one byte, handed from decoder to output buffer.
    typedef struct packed {
        logic [1:0]  n;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } dec_units_t;

endpackage

// ===== src/u2u_decoder.sv =====
// Sequence state and per-byte decode into UTF-16 units.
`include "utf8_to_utf16_transcoder_defines.svh"

module u2u_decoder
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  byte_in,
    input  logic        string_end,
    output dec_units_t  units
);

    logic [1:0]  br_reg;
    logic [1:0]  br_next;
    logic [20:0] pp_reg;
    logic [20:0] pp_next;
    logic        halted_reg;
    logic        halted_next;

    logic        done;
    logic [20:0] cp;
    logic [20:0] pp_merge;
    logic [20:0] v;

    always_comb
    begin
        br_next     = br_reg;
        pp_next     = pp_reg;
        halted_next = halted_reg;
        done        = 1'b0;
        cp          = 21'd0;
        pp_merge    = pp_reg;
        units.n     = 2'd0;
        units.unit0 = 16'd0;
        units.unit1 = 16'd0;
        v           = 21'd0;

        if (!halted_reg)
        begin
            if (br_reg == 2'd0)
            begin
                if (!byte_in[7])
                begin
                    done = 1'b1;
                    cp   = {13'd0, byte_in};
                end
                else if (byte_in[7:5] == LEAD2_TAG)
                begin
                    br_next = 2'd1;
                    pp_next = {10'd0, byte_in[4:0], 6'd0};
                end
                else if (byte_in[7:4] == LEAD3_TAG)
                begin
                    br_next = 2'd2;
                    pp_next = {5'd0, byte_in[3:0], 12'd0};
                end
                else if (byte_in[7:3] == LEAD4_TAG)
                begin
                    br_next = 2'd3;
                    pp_next = {byte_in[2:0], 18'd0};
                end
                else
                begin
                    halted_next = 1'b1;
                end
            end
            else if (byte_in[7:6] == CONT_TAG)
            begin
                case (br_reg)
                    2'd1:    pp_merge = pp_reg | {15'd0, byte_in[5:0]};
                    2'd2:    pp_merge = pp_reg | {9'd0, byte_in[5:0], 6'd0};
                    default: pp_merge = pp_reg | {3'd0, byte_in[5:0], 12'd0};
                endcase
                br_next = br_reg - 2'd1;
                if (br_reg == 2'd1)
                begin
                    done    = 1'b1;
                    cp      = pp_merge;
                    pp_next = 21'd0;
                end
                else
                begin
                    pp_next = pp_merge;
                end
            end
            else
            begin
                halted_next = 1'b1;
            end
        end

        if (done)
        begin
            v = cp - CP_SUPP_BASE;
            if (cp <= CP_BMP_MAX)
            begin
                units.n     = 2'd1;
                units.unit0 = cp[15:0];
            end
            else if (cp <= CP_MAX)
            begin
                units.n     = 2'd2;
                units.unit0 = HI_SURR | {6'd0, v[19:10]};
                units.unit1 = LO_SURR | {6'd0, v[9:0]};
            end
            else
            begin
                halted_next = 1'b1;
            end
        end

        if (string_end)
        begin
            br_next     = 2'd0;
            pp_next     = 21'd0;
            halted_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            br_reg     <= 2'd0;
            pp_reg     <= 21'd0;
            halted_reg <= 1'b0;
        end
        else if (step)
        begin
            br_reg     <= br_next;
            pp_reg     <= pp_next;
            halted_reg <= halted_next;
        end
    end

    `U2U_ASSERT_IMPL(a_halt_quiet, halted_reg, units.n == 2'd0)
    `U2U_ASSERT_IMPL(a_idle_no_partial, br_reg == 2'd0, pp_reg == 21'd0)
    `U2U_ASSERT_IMPL(a_pair_high_first, units.n == 2'd2, units.unit0[15:10] == 6'b110110)

endmodule

// ===== src/u2u_out_buf.sv =====
// Two-unit result buffer that sends a surrogate pair over two transfers.
`include "utf8_to_utf16_transcoder_defines.svh"

module u2u_out_buf
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  dec_units_t  units,
    output logic        load_ok,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tlast    // unit_last
);

    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic [15:0] slot0_reg;
    logic [15:0] slot0_next;
    logic        slot0_last_reg;
    logic        slot0_last_next;
    logic [15:0] slot1_reg;
    logic [15:0] slot1_next;
    logic        pop;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = slot0_reg;
    assign m_tlast  = slot0_last_reg;
    assign pop      = m_tvalid && m_tready;
    assign load_ok  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);

    always_comb
    begin
        cnt_next        = cnt_reg;
        slot0_next      = slot0_reg;
        slot0_last_next = slot0_last_reg;
        slot1_next      = slot1_reg;
        if (load)
        begin
            cnt_next        = units.n;
            slot0_next      = units.unit0;
            slot0_last_next = (units.n != 2'd2);
            slot1_next      = units.unit1;
        end
        else if (pop)
        begin
            cnt_next        = cnt_reg - 2'd1;
            slot0_next      = slot1_reg;
            slot0_last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg      <= slot0_next;
        slot0_last_reg <= slot0_last_next;
        slot1_reg      <= slot1_next;
    end

    `U2U_ASSERT(a_cnt_range, cnt_reg != 2'd3)
    `U2U_ASSERT_IMPL(a_pair_first_not_last, cnt_reg == 2'd2, !slot0_last_reg)
    `U2U_ASSERT_IMPL(a_stall_holds, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))

endmodule

// ===== src/utf8_to_utf16_transcoder.sv =====
// Top level: input register, decoder and result buffer of the transcoder.
// An accepted byte goes through the input register, then the result buffer.
// One byte per cycle while the receiver is ready; a pair takes two transfers.
// Bytes that produce no unit pass at one per cycle while the buffer can load.
// Reset (rst_n low, asynchronous) clears the valid flags and the sequence state;
// data registers are not reset.
module utf8_to_utf16_transcoder
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tlast,   // string_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tlast    // unit_last
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       load_ok;
    logic       advance;
    dec_units_t units;

    assign advance  = in_valid_reg && load_ok;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    u2u_decoder u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .byte_in    (in_byte_reg),
        .string_end (in_last_reg),
        .units      (units)
    );

    u2u_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .units    (units),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the UTF-8 to UTF-16 transcoder.
module tb
    import u2u_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] code;
        logic        fin;
    } utf16_unit_t;

    // Tracks the decoder state and holds the UTF-16 units still owed by the block.
    class utf16_scoreboard;
        logic [1:0]  cont_left;
        logic [20:0] partial_cp;
        logic        halted;
        utf16_unit_t expected_units[$];
        int          mismatches;
        int          units_checked;
        int          bytes_seen;
        int          bytes_decoded;
        int          pairs_owed;
        int          halts;

        function new();
            cont_left  = '0;
            partial_cp = '0;
            halted     = 1'b0;
        endfunction

        function void queue_unit(logic [15:0] code, logic fin);
            utf16_unit_t u;
            u.code = code;
            u.fin  = fin;
            expected_units.insert(expected_units.size(), u);
        endfunction

        function void put_point(logic [20:0] cp);
            logic [20:0] v;
            if (cp <= CP_BMP_MAX) begin
                queue_unit(cp[15:0], 1'b1);
            end
            else if (cp <= CP_MAX) begin
                v = cp - CP_SUPP_BASE;
                queue_unit(HI_SURR | {6'd0, v[19:10]}, 1'b0);
                queue_unit(LO_SURR | {6'd0, v[9:0]}, 1'b1);
                pairs_owed++;
            end
            else begin
                halted = 1'b1;
                halts++;
            end
        endfunction

        function void note_byte(logic [7:0] b, logic string_end);
            logic [4:0] shift;
            bytes_seen++;
            if (!halted) begin
                bytes_decoded++;
                if (cont_left == 0) begin
                    if (!b[7]) begin
                        put_point({13'd0, b});
                    end
                    else if (b[7:5] == LEAD2_TAG) begin
                        cont_left  = 2'd1;
                        partial_cp = {10'd0, b[4:0], 6'd0};
                    end
                    else if (b[7:4] == LEAD3_TAG) begin
                        cont_left  = 2'd2;
                        partial_cp = {5'd0, b[3:0], 12'd0};
                    end
                    else if (b[7:3] == LEAD4_TAG) begin
                        cont_left  = 2'd3;
                        partial_cp = {b[2:0], 18'd0};
                    end
                    else begin
                        halted = 1'b1;
                        halts++;
                    end
                end
                else if (b[7:6] == CONT_TAG) begin
                    shift      = 5'(6 * (cont_left - 2'd1));
                    partial_cp = partial_cp | (21'(b[5:0]) << shift);
                    cont_left  = cont_left - 2'd1;
                    if (cont_left == 0) begin
                        put_point(partial_cp);
                        partial_cp = '0;
                    end
                end
                else begin
                    halted = 1'b1;
                    halts++;
                end
            end
            // end of string drops any partial sequence and clears the halt
            if (string_end) begin
                cont_left  = '0;
                partial_cp = '0;
                halted     = 1'b0;
            end
        endfunction

        function void flag(string what, utf16_unit_t want, utf16_unit_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s: expected unit %h last %b, got unit %h last %b",
                         $realtime, what, want.code, want.fin, got.code, got.fin);
        endfunction

        function void check_unit(logic [15:0] code, logic fin);
            utf16_unit_t want;
            utf16_unit_t got;
            got = '{code, fin};
            units_checked++;
            if (expected_units.size() == 0) begin
                flag("unit with nothing pending", '0, got);
            end
            else begin
                want = expected_units.pop_front();
                if (want.code !== got.code)
                    flag("code unit mismatch", want, got);
                else if (want.fin !== got.fin)
                    flag("last flag mismatch", want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    utf16_scoreboard sb;
    logic [7:0]      str_bytes[$];
    int              burst_left;
    int              rx_mode;
    int              rx_stretch;
    int              rx_hold;
    int              random_start;

    utf8_to_utf16_transcoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Called just after a falling edge; returns just after the falling edge that follows the byte's acceptance.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = fin;
        do @(posedge clk); while (!s_tready);
        sb.note_byte(b, fin);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_string();
        int i;
        for (i = 0; i < str_bytes.size(); i++)
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
        str_bytes.delete();
    endtask

    task automatic wait_drain();
        s_tvalid = 1'b0;
        while (sb.expected_units.size() != 0) @(negedge clk);
    endtask

    function automatic logic [7:0] cont_byte();
        return {CONT_TAG, 6'($urandom_range(0, 63))};
    endfunction

    function automatic void append_byte(input logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endfunction

    // Appends one sequence of 1 to 4 bytes with random content; a 4-byte one may be too large.
    task automatic add_point(input int len);
        logic [2:0] top;
        case (len)
            1: append_byte(8'($urandom_range(0, 127)));
            2: append_byte({LEAD2_TAG, 5'($urandom_range(0, 31))});
            3: append_byte({LEAD3_TAG, 4'($urandom_range(0, 15))});
            default:
            begin
                top = 3'($urandom_range(0, 4));
                // now and then a lead that can only give a code point too large
                if ($urandom_range(0, 15) == 0)
                    top = 3'($urandom_range(5, 7));
                append_byte({LEAD4_TAG, top});
            end
        endcase
        repeat (len - 1) append_byte(cont_byte());
    endtask

    task automatic add_random_string();
        int n;
        int r;
        int len;
        n = $urandom_range(1, 10);
        repeat (n) begin
            r   = $urandom_range(0, 99);
            len = $urandom_range(1, 4);
            if (r < 85) begin
                add_point(len);
            end
            else if (r < 90) begin
                append_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 95) begin
                // sequence cut short: its last continuation byte is dropped
                add_point($urandom_range(2, 4));
                void'(str_bytes.pop_back());
            end
            else begin
                add_point($urandom_range(2, 4));
                str_bytes[str_bytes.size() - 1] = 8'($urandom_range(0, 255));
            end
        end
    endtask

    // Receiver ready pattern: free-running, coin-flip, and long-stall stretches.
    initial
    begin
        m_tready   = 1'b0;
        rx_stretch = 0;
        rx_hold    = 0;
        rx_mode    = 0;
        forever begin
            @(negedge clk);
            if (rx_stretch == 0) begin
                rx_mode    = $urandom_range(0, 2);
                rx_stretch = $urandom_range(20, 120);
            end
            rx_stretch--;
            case (rx_mode)
                0: m_tready = 1'b1;
                1: m_tready = 1'($urandom_range(0, 1));
                default:
                begin
                    if (rx_hold > 0) begin
                        m_tready = 1'b0;
                        rx_hold--;
                    end
                    else begin
                        m_tready = 1'b1;
                        rx_hold  = $urandom_range(1, 6);
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_unit(m_tdata, m_tlast);
    end

    initial
    begin
        sb         = new();
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ASCII extremes in one string
        str_bytes = {8'h00, 8'h7F};
        send_string();
        str_bytes = {8'hC2, 8'h80};
        send_string();
        // surrogate code point passes through
        str_bytes = {8'hED, 8'hA0, 8'h80};
        send_string();
        // smallest and largest supplementary points
        str_bytes = {8'hF0, 8'h90, 8'h80, 8'h80};
        send_string();
        str_bytes = {8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        // too large, then a byte ignored while halted
        str_bytes = {8'hF4, 8'h90, 8'h80, 8'h80, 8'h41};
        send_string();
        // stray continuation as lead
        str_bytes = {8'h80};
        send_string();
        str_bytes = {8'hF8};
        send_string();
        // bad continuation
        str_bytes = {8'hC2, 8'h41};
        send_string();
        // string ends inside a sequence
        str_bytes = {8'hE0, 8'h80};
        send_string();
        wait_drain();

        random_start = sb.bytes_seen;
        while (sb.bytes_seen - random_start < 1400) begin
            add_random_string();
            send_string();
            if ($urandom_range(0, 39) == 0)
                wait_drain();
        end

        wait_drain();
        repeat (8) @(negedge clk);
        $display("Sent %0d bytes (%0d decoded), %0d halts; checked %0d units, %0d pairs.",
                 sb.bytes_seen, sb.bytes_decoded, sb.halts, sb.units_checked,
                 sb.pairs_owed);
        $display("Mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_units.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("Timeout with %0d units pending", sb.expected_units.size());
        $display("tb: failure");
        $finish;
    end

endmodule
